// ===== src/dmar_pkg.sv =====
// shared constants for the dual moving average risk block
`default_nettype none

package dmar_pkg;

  localparam int WindowLengthDefault = 10;

  localparam int SampleW = 12;
  localparam int RiskW   = 7;

  localparam int FullScale    = 4095;
  localparam int LightWeight  = 35;
  localparam int ResistWeight = 65;
  localparam int PercentMax   = 100;
  localparam int ScoreDivisor = FullScale * (LightWeight + ResistWeight);
  localparam int ScoreHalf    = ScoreDivisor / 2;

  // weighted sum up to 409500, scaled numerator below 2^27
  localparam int WSumW     = 19;
  localparam int ScoreNumW = 27;

  // average divider: quotient bits per cycle and number of steps
  localparam int DivBits  = 3;
  localparam int DivSteps = SampleW / DivBits;
  localparam int DivStepW = $clog2(DivSteps);

  // score division: 8 quotient bits, 4 per cycle
  localparam int ScoreQuoW  = 8;
  localparam int ScoreBits  = 4;

  localparam int InDataW  = 2 * SampleW;
  localparam int OutDataW = 32;

endpackage

`default_nettype wire

// ===== src/dmar_ring_mem.sv =====
// sample ring memory, one write port and one registered read port
`default_nettype none

module dmar_ring_mem #(
  parameter int DEPTH  = 10,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 24
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/dmar_divider.sv =====
// iterative divider for both window totals by the fill count
`default_nettype none

module dmar_divider import dmar_pkg::*; #(
  parameter int CNT_W = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [CNT_W+SampleW-1:0] light_total_i,
  input  wire logic [CNT_W+SampleW-1:0] res_total_i,
  input  wire logic [CNT_W-1:0]         count_i,
  output logic                          done_o,
  output logic      [SampleW-1:0]       light_avg_o,
  output logic      [SampleW-1:0]       res_avg_o
);

  localparam int TotW = CNT_W + SampleW;

  logic                busy_q;
  logic                done_q;
  logic [DivStepW-1:0] step_q;
  logic [TotW-1:0]     lrem_q, lrem_d;
  logic [TotW-1:0]     rrem_q, rrem_d;
  logic [TotW-1:0]     dsh_q;
  logic [SampleW-1:0]  lquo_q, lquo_d;
  logic [SampleW-1:0]  rquo_q, rquo_d;

  always_comb begin
    logic [TotW-1:0]    sh;
    logic [DivBits-1:0] lbits;
    logic [DivBits-1:0] rbits;
    lrem_d = lrem_q;
    rrem_d = rrem_q;
    lbits  = '0;
    rbits  = '0;
    for (int k = 0; k < DivBits; k++) begin
      sh = dsh_q << (DivBits - 1 - k);
      if (lrem_d >= sh) begin
        lrem_d = lrem_d - sh;
        lbits[DivBits-1-k] = 1'b1;
      end
      if (rrem_d >= sh) begin
        rrem_d = rrem_d - sh;
        rbits[DivBits-1-k] = 1'b1;
      end
    end
    lquo_d = {lquo_q[SampleW-DivBits-1:0], lbits};
    rquo_d = {rquo_q[SampleW-DivBits-1:0], rbits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + DivStepW'(1);
        if (step_q == DivStepW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lrem_q <= light_total_i;
      rrem_q <= res_total_i;
      dsh_q  <= TotW'(count_i) << (SampleW - DivBits);
      lquo_q <= '0;
      rquo_q <= '0;
    end else if (busy_q) begin
      lrem_q <= lrem_d;
      rrem_q <= rrem_d;
      dsh_q  <= dsh_q >> DivBits;
      lquo_q <= lquo_d;
      rquo_q <= rquo_d;
    end
  end

  assign done_o      = done_q;
  assign light_avg_o = lquo_q;
  assign res_avg_o   = rquo_q;

endmodule

`default_nettype wire

// ===== src/dmar_score.sv =====
// weighted risk score with rounding and saturation
`default_nettype none

module dmar_score import dmar_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [SampleW-1:0] light_avg_i,
  input  wire logic [SampleW-1:0] res_avg_i,
  output logic                    done_o,
  output logic      [RiskW-1:0]   risk_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [1:0]           phase_q;
  logic [SampleW-1:0]   la_q, ra_q;
  logic [WSumW-1:0]     wsum_q;
  logic [ScoreNumW-1:0] rem_q, rem_d;
  logic [ScoreNumW-1:0] dsh_q;
  logic [ScoreQuoW-1:0] quo_q, quo_d;

  always_comb begin
    logic [ScoreNumW-1:0] sh;
    logic [ScoreBits-1:0] qbits;
    rem_d = rem_q;
    qbits = '0;
    for (int k = 0; k < ScoreBits; k++) begin
      sh = dsh_q << (ScoreBits - 1 - k);
      if (rem_d >= sh) begin
        rem_d = rem_d - sh;
        qbits[ScoreBits-1-k] = 1'b1;
      end
    end
    quo_d = {quo_q[ScoreQuoW-ScoreBits-1:0], qbits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= '0;
      end else if (busy_q) begin
        phase_q <= phase_q + 2'd1;
        if (phase_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      la_q <= light_avg_i;
      ra_q <= res_avg_i;
    end else if (busy_q) begin
      case (phase_q)
        2'd0: begin
          wsum_q <= WSumW'(la_q) * WSumW'(LightWeight)
                  + WSumW'(ra_q) * WSumW'(ResistWeight);
        end
        2'd1: begin
          rem_q <= ScoreNumW'(wsum_q) * ScoreNumW'(PercentMax) + ScoreNumW'(ScoreHalf);
          dsh_q <= ScoreNumW'(ScoreDivisor) << (ScoreQuoW - ScoreBits);
          quo_q <= '0;
        end
        default: begin
          rem_q <= rem_d;
          dsh_q <= dsh_q >> ScoreBits;
          quo_q <= quo_d;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign risk_o = (quo_q > ScoreQuoW'(PercentMax)) ? RiskW'(PercentMax) : quo_q[RiskW-1:0];

endmodule

`default_nettype wire

// ===== src/dual_moving_average_risk.sv =====
// dual moving average filter with weighted risk score, top level
// an input transaction goes through the update, divide and score states before the result is offered on the output
// a new input is accepted only after the previous result is loaded into the output register, so the pace is set
//   by the average divider (3 quotient bits a cycle) and the score unit (multiply, scale, 2 divide steps)
// the output register holds a result until taken while the next input is not yet blocked
// reset clears totals, write slot, fill count and handshake state; ring contents stay undefined
`default_nettype none

module dual_moving_average_risk import dmar_pkg::*; #(
  parameter int WINDOW_LENGTH = WindowLengthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // light_sample [11:0], resistance_sample [23:12]
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // light_average [11:0], resistance_average [23:12], risk_level [30:24], zero [31]
  output logic      [OutDataW-1:0] m_axis_tdata_o
);

  localparam int CntW  = $clog2(WINDOW_LENGTH + 1);
  localparam int SlotW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int TotW  = CntW + SampleW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_UPD   = 5'b00010,
    S_DIV   = 5'b00100,
    S_SCORE = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [SampleW-1:0] light_q, res_q;
  logic [SlotW-1:0]   slot_q;
  logic [CntW-1:0]    count_q;
  logic [TotW-1:0]    ltot_q, rtot_q;
  logic [TotW-1:0]    ltot_d, rtot_d;
  logic [CntW-1:0]    count_d;

  logic               in_fire;
  logic               full;
  logic [InDataW-1:0] old_data;
  logic               upd;

  logic               div_done;
  logic [SampleW-1:0] lavg, ravg;
  logic               score_start;
  logic               score_done;
  logic [RiskW-1:0]   risk;
  logic               out_free;
  logic               out_load;

  logic               out_valid_q;
  logic [SampleW-1:0] out_lavg_q, out_ravg_q;
  logic [RiskW-1:0]   out_risk_q;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign upd             = (state_q == S_UPD);
  assign full            = (count_q == CntW'(WINDOW_LENGTH));
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign out_load        = (state_q == S_OUT) && out_free;
  assign score_start     = (state_q == S_DIV) && div_done;

  dmar_ring_mem #(
    .DEPTH  (WINDOW_LENGTH),
    .ADDR_W (SlotW),
    .DATA_W (InDataW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (upd),
    .waddr_i (slot_q),
    .wdata_i ({res_q, light_q}),
    .re_i    (in_fire),
    .raddr_i (slot_q),
    .rdata_o (old_data)
  );

  always_comb begin
    ltot_d  = ltot_q + TotW'(light_q);
    rtot_d  = rtot_q + TotW'(res_q);
    count_d = count_q;
    if (full) begin
      ltot_d = ltot_d - TotW'(old_data[SampleW-1:0]);
      rtot_d = rtot_d - TotW'(old_data[InDataW-1:SampleW]);
    end else begin
      count_d = count_q + CntW'(1);
    end
  end

  dmar_divider #(
    .CNT_W (CntW)
  ) u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (upd),
    .light_total_i (ltot_d),
    .res_total_i   (rtot_d),
    .count_i       (count_d),
    .done_o        (div_done),
    .light_avg_o   (lavg),
    .res_avg_o     (ravg)
  );

  dmar_score u_score (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (score_start),
    .light_avg_i (lavg),
    .res_avg_i   (ravg),
    .done_o      (score_done),
    .risk_o      (risk)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_UPD;
      S_UPD:   state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_SCORE;
      S_SCORE: if (score_done) state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      count_q     <= '0;
      ltot_q      <= '0;
      rtot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (upd) begin
        ltot_q  <= ltot_d;
        rtot_q  <= rtot_d;
        count_q <= count_d;
        if (slot_q == SlotW'(WINDOW_LENGTH - 1)) begin
          slot_q <= '0;
        end else begin
          slot_q <= slot_q + SlotW'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      light_q <= s_axis_tdata_i[SampleW-1:0];
      res_q   <= s_axis_tdata_i[InDataW-1:SampleW];
    end
    if (out_load) begin
      out_lavg_q <= lavg;
      out_ravg_q <= ravg;
      out_risk_q <= risk;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - 2 * SampleW - RiskW){1'b0}},
                            out_risk_q, out_ravg_q, out_lavg_q};

endmodule

`default_nettype wire
